FILE: src/lfu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared types and constants for the LFU cache table.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int unsigned CAP_W   = 7;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned STAMP_W = 48;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  localparam logic [CAP_W-1:0]  CAP_RESET = 7'd64;
  localparam logic [WORD_W-1:0] MISS_VALUE = '1;   // -1 on a get miss
  localparam logic [WORD_W-1:0] COUNT_MAX  = '1;   // use count saturates here

  typedef struct packed {
    logic              command;
    logic signed [31:0] key;
    logic signed [31:0] put_value;
  } in_beat_t;

  typedef struct packed {
    logic              hit;
    logic signed [31:0] read_value;
    logic              evicted;
    logic signed [31:0] evicted_key;
  } out_beat_t;

  // One table row as held in the memory.
  typedef struct packed {
    logic               valid;
    logic [WORD_W-1:0]  key;
    logic [WORD_W-1:0]  data;
    logic [WORD_W-1:0]  count;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  // Summary of one pass over the table.
  typedef struct packed {
    logic              match;
    entry_t            match_ent;
    logic              free_found;
    logic              victim_found;
    logic [WORD_W-1:0] victim_key;
  } scan_sum_t;

endpackage
`default_nettype wire

FILE: src/lfu_cache_table_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_cache_table_top
// Least-frequently-used key/value table with a sequential scan over one
// synchronous entry memory.
// ----------------------------------------------------------------------------
//  channel | ports                          | beat
//  --------+--------------------------------+-------------------------------
//  input   | in_valid / in_ready / in_beat  | command, key, put_value
//  result  | out_valid / out_ready / out_beat| hit, read_value, evicted, evicted_key
//  config  | cfg_wr_en / cfg_wr_data        | capacity (7 bits)
//
// An item is handled in order: one read per entry through the single memory
// read port, then the last read data, the write-back, loading the result,
// and the return to idle.
// With capacity zero an item goes from accept straight to loading the result
// and touches nothing.
// After reset a clearing pass over every entry zeroes the valid bits;
// in_ready stays low meanwhile, config writes are still taken.
// A result waits in the output register while a new item is accepted; the
// block stalls before loading the next result until out_ready frees it.
// ----------------------------------------------------------------------------
module lfu_cache_table_top #(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire lfu_pkg::in_beat_t        in_beat,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output lfu_pkg::out_beat_t            out_beat,
  input  wire logic                     cfg_wr_en,
  input  wire logic [lfu_pkg::CAP_W-1:0] cfg_wr_data
);
  import lfu_pkg::*;

  localparam int unsigned AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned OCC_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;
  localparam logic [AW-1:0]    LAST_IDX = AW'(MAX_ENTRIES - 1);
  localparam logic [CMP_W-1:0] MAX_CMP  = CMP_W'(MAX_ENTRIES);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_SCAN, ST_TAIL, ST_DECIDE, ST_RESP
  } state_t;

  state_t             state_r;
  logic [AW-1:0]      idx_r;        // scan address, also clear address
  logic               rd_vld_r;
  logic [AW-1:0]      rd_idx_r;
  in_beat_t           req_r;
  out_beat_t          res_r;
  out_beat_t          out_r;
  logic               out_valid_r;
  logic [CAP_W-1:0]   capacity_r;
  logic [OCC_W-1:0]   occ_r;
  logic [STAMP_W-1:0] touch_r;

  // memory and scan hookup
  entry_t             rd_ent;
  scan_sum_t          sum;
  logic [AW-1:0]      match_idx, victim_idx, free_idx;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  entry_t             wr_ent;

  logic               in_acc;
  logic [CMP_W-1:0]   cap_ext, cap_eff, occ_ext;
  logic               full;

  // decide-step results
  logic               do_evict, do_insert;
  logic [WORD_W-1:0]  count_inc;
  out_beat_t          res_dec;
  logic [OCC_W-1:0]   occ_dec;
  logic               touch_step;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_beat  = out_r;

  always_comb begin
    cap_ext = CMP_W'(capacity_r);
    cap_eff = (cap_ext > MAX_CMP) ? MAX_CMP : cap_ext;
    occ_ext = CMP_W'(occ_r);
    full    = (occ_ext >= cap_eff);
  end

  lfu_mem #(.DEPTH(MAX_ENTRIES), .AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_ent  (wr_ent),
    .rd_addr (idx_r),
    .rd_ent  (rd_ent)
  );

  lfu_scan #(.AW(AW)) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_acc),
    .key        (req_r.key),
    .rd_vld     (rd_vld_r),
    .rd_idx     (rd_idx_r),
    .rd_ent     (rd_ent),
    .sum        (sum),
    .match_idx  (match_idx),
    .victim_idx (victim_idx),
    .free_idx   (free_idx)
  );

  // Write-back decision once the whole table has been seen.
  always_comb begin
    count_inc  = (sum.match_ent.count == COUNT_MAX) ? sum.match_ent.count
                                                    : sum.match_ent.count + 1'b1;
    do_evict   = 1'b0;
    do_insert  = 1'b0;
    occ_dec    = occ_r;
    touch_step = 1'b0;
    res_dec    = '0;
    wr_en      = 1'b0;
    wr_addr    = match_idx;
    wr_ent     = sum.match_ent;

    if (state_r == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = idx_r;
      wr_ent  = '0;
    end else if (state_r == ST_DECIDE) begin
      if (sum.match) begin
        // hit: bump count, restamp, replace data on a put
        res_dec.hit        = 1'b1;
        res_dec.read_value = (req_r.command == CMD_GET) ? sum.match_ent.data : '0;
        wr_en              = 1'b1;
        wr_ent.count       = count_inc;
        wr_ent.stamp       = touch_r;
        if (req_r.command == CMD_PUT) begin
          wr_ent.data = req_r.put_value;
        end
        touch_step = 1'b1;
      end else if (req_r.command == CMD_GET) begin
        res_dec.read_value = MISS_VALUE;
      end else begin
        do_evict  = full && sum.victim_found;
        do_insert = do_evict || sum.free_found;
        if (do_evict) begin
          res_dec.evicted     = 1'b1;
          res_dec.evicted_key = sum.victim_key;
          wr_addr             = victim_idx;
        end else begin
          wr_addr = free_idx;
          occ_dec = occ_r + 1'b1;
        end
        wr_en        = do_insert;
        wr_ent.valid = 1'b1;
        wr_ent.key   = req_r.key;
        wr_ent.data  = req_r.put_value;
        wr_ent.count = WORD_W'(1);
        wr_ent.stamp = touch_r;
        touch_step   = do_insert;
        if (!do_insert) begin
          occ_dec = occ_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      idx_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      capacity_r  <= CAP_RESET;
      occ_r       <= '0;
      touch_r     <= '0;
    end else begin
      if (cfg_wr_en) begin
        capacity_r <= cfg_wr_data;
      end
      // in ST_RESP the case arm below owns out_valid_r
      if (out_valid_r && out_ready && (state_r != ST_RESP)) begin
        out_valid_r <= 1'b0;
      end
      rd_vld_r <= (state_r == ST_SCAN);
      rd_idx_r <= idx_r;

      case (state_r)
        ST_CLEAR: begin
          if (idx_r == LAST_IDX) begin
            idx_r   <= '0;
            state_r <= ST_IDLE;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            req_r <= in_beat;
            idx_r <= '0;
            if (cap_eff == '0) begin
              // zero capacity: miss, no state change
              res_r   <= '{hit:         1'b0,
                           read_value:  (in_beat.command == CMD_GET) ? MISS_VALUE : '0,
                           evicted:     1'b0,
                           evicted_key: '0};
              state_r <= ST_RESP;
            end else begin
              state_r <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (idx_r == LAST_IDX) begin
            idx_r   <= '0;
            state_r <= ST_TAIL;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        ST_TAIL: begin
          state_r <= ST_DECIDE;
        end
        ST_DECIDE: begin
          res_r   <= res_dec;
          occ_r   <= occ_dec;
          if (touch_step) begin
            touch_r <= touch_r + 1'b1;
          end
          state_r <= ST_RESP;
        end
        ST_RESP: begin
          if (!out_valid_r || out_ready) begin
            out_r       <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: src/lfu_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lfu_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire lfu_pkg::entry_t wr_ent,
  input  wire logic [AW-1:0]   rd_addr,
  output lfu_pkg::entry_t      rd_ent
);
  import lfu_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_ent;
    end
    rd_ent <= mem[rd_addr];
  end

endmodule
`default_nettype wire

FILE: src/lfu_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_scan
// Walks the read stream of the table: first key match, first free slot,
// and the eviction candidate (lowest count, then oldest stamp, then index).
// ----------------------------------------------------------------------------
module lfu_scan #(
  parameter int unsigned AW = 6
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [31:0]       key,
  input  wire logic              rd_vld,
  input  wire logic [AW-1:0]     rd_idx,
  input  wire lfu_pkg::entry_t   rd_ent,
  output lfu_pkg::scan_sum_t     sum,
  output logic [AW-1:0]          match_idx,
  output logic [AW-1:0]          victim_idx,
  output logic [AW-1:0]          free_idx
);
  import lfu_pkg::*;

  logic               match_r, free_found_r, victim_found_r;
  entry_t             match_ent_r;
  logic [AW-1:0]      match_idx_r, victim_idx_r, free_idx_r;
  logic [WORD_W-1:0]  vic_count_r, vic_key_r;
  logic [STAMP_W-1:0] vic_stamp_r;

  logic take_match, take_free, take_victim;

  always_comb begin
    take_match  = rd_vld && rd_ent.valid && (rd_ent.key == key) && !match_r;
    take_free   = rd_vld && !rd_ent.valid && !free_found_r;
    take_victim = rd_vld && rd_ent.valid &&
                  (!victim_found_r || (rd_ent.count < vic_count_r) ||
                   ((rd_ent.count == vic_count_r) && (rd_ent.stamp < vic_stamp_r)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n || start) begin
      match_r        <= 1'b0;
      free_found_r   <= 1'b0;
      victim_found_r <= 1'b0;
    end else begin
      if (take_match) begin
        match_r <= 1'b1;
      end
      if (take_free) begin
        free_found_r <= 1'b1;
      end
      if (take_victim) begin
        victim_found_r <= 1'b1;
      end
    end
    if (take_match) begin
      match_ent_r <= rd_ent;
      match_idx_r <= rd_idx;
    end
    if (take_free) begin
      free_idx_r <= rd_idx;
    end
    if (take_victim) begin
      victim_idx_r <= rd_idx;
      vic_count_r  <= rd_ent.count;
      vic_stamp_r  <= rd_ent.stamp;
      vic_key_r    <= rd_ent.key;
    end
  end

  always_comb begin
    sum.match        = match_r;
    sum.match_ent    = match_ent_r;
    sum.free_found   = free_found_r;
    sum.victim_found = victim_found_r;
    sum.victim_key   = vic_key_r;
    match_idx        = match_idx_r;
    victim_idx       = victim_idx_r;
    free_idx         = free_idx_r;
  end

endmodule
`default_nettype wire
